// ===== sv/png_scanline_unfilter_defines.svh =====
// Assertion macros for the scanline unfilter top level.
`ifndef PNG_SCANLINE_UNFILTER_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_DEFINES_SVH

// Same-cycle implication.
`define PSU_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("psu: same-cycle check failed");

// Next-cycle implication.
`define PSU_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("psu: next-cycle check failed");

`endif

// ===== sv/psu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_pkg
// Types, constants and the Paeth predictor for the scanline unfilter.
// ----------------------------------------------------------------------------
package psu_pkg;

   localparam int MAX_ROW_BYTES_DEF = 8192;
   localparam int MAX_PIXEL_BYTES   = 8;
   localparam int SLOT_W            = 3;

   localparam int ROW_BYTES_W   = 14;
   localparam int PIXEL_BYTES_W = 4;
   localparam int IMAGE_ROWS_W  = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_IDX_W     = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_BYTES   = 2'd0,
      CSR_PIXEL_BYTES = 2'd1,
      CSR_IMAGE_ROWS  = 2'd2
   } csr_index_type;

   typedef enum logic [7:0] {
      FLT_NONE  = 8'd0,
      FLT_SUB   = 8'd1,
      FLT_UP    = 8'd2,
      FLT_AVG   = 8'd3,
      FLT_PAETH = 8'd4
   } filter_type;

   // one data byte handed from the sequencer to the reconstruct stage
   typedef struct packed {
      logic              valid;
      logic [7:0]        data;
      logic [7:0]        filter;
      logic [SLOT_W-1:0] slot;
      logic              left_ok;
      logic              above_ok;
      logic              row_end;
      logic              image_end;
   } item_type;

   function automatic logic [7:0] paeth_pred(input logic [7:0] a,
                                             input logic [7:0] b,
                                             input logic [7:0] c);
      logic [8:0] dist_a;
      logic [8:0] dist_b;
      logic [8:0] dist_c;
      logic [8:0] sum_ab;
      logic [8:0] twice_c;
      logic [7:0] pick;
      sum_ab  = {1'b0, a} + {1'b0, b};
      twice_c = {c, 1'b0};
      dist_a  = (b > c) ? ({1'b0, b} - {1'b0, c}) : ({1'b0, c} - {1'b0, b});
      dist_b  = (a > c) ? ({1'b0, a} - {1'b0, c}) : ({1'b0, c} - {1'b0, a});
      dist_c  = (sum_ab > twice_c) ? (sum_ab - twice_c) : (twice_c - sum_ab);
      if (dist_a <= dist_b && dist_a <= dist_c) begin
         pick = a;
      end else if (dist_b <= dist_c) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

// ===== sv/psu_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_req_if
// Input byte stream channel.
// ----------------------------------------------------------------------------
interface psu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== sv/psu_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_rsp_if
// Reconstructed byte channel with row and image end flags.
// ----------------------------------------------------------------------------
interface psu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   logic       row_end;
   logic       image_end;

   modport source (output valid, output pixel_byte, output row_end, output image_end,
                   input ready);
   modport sink   (input valid, input pixel_byte, input row_end, input image_end,
                   output ready);
endinterface

// ===== sv/psu_csr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_csr_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface psu_csr_if import psu_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/psu_line_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_line_ram
// Previous-row line store. One read and one write port, registered read data.
// The write goes to the address of the last read.
// ----------------------------------------------------------------------------
module psu_line_ram import psu_pkg::*; #(
   parameter  int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
   localparam int COL_W         = $clog2(MAX_ROW_BYTES)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   output logic [7:0]       rd_data,
   input  logic             wr_en,
   input  logic [7:0]       wr_data
);

   logic [7:0]       mem [MAX_ROW_BYTES];
   logic [7:0]       rd_data_ff;
   logic [COL_W-1:0] addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         addr_ff    <= rd_addr;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/psu_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_seq
// Register file, column/row counters and filter byte capture. Issues the
// line store read and hands each data byte to the reconstruct stage.
// ----------------------------------------------------------------------------
module psu_seq import psu_pkg::*; #(
   parameter  int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
   localparam int COL_W         = $clog2(MAX_ROW_BYTES)
) (
   input  logic             clock,
   input  logic             reset,
   psu_req_if.sink          req,
   psu_csr_if.sink          csr,
   input  logic             take_ok,
   output item_type         item,
   output logic             rd_en,
   output logic [COL_W-1:0] rd_addr
);

   localparam int CNT_W = ((COL_W > ROW_BYTES_W) ? COL_W : ROW_BYTES_W) + 1;

   logic [ROW_BYTES_W-1:0]   row_bytes_ff, row_bytes_in;
   logic [PIXEL_BYTES_W-1:0] pixel_bytes_ff, pixel_bytes_in;
   logic [IMAGE_ROWS_W-1:0]  image_rows_ff, image_rows_in;
   logic [COL_W-1:0]         column_ff, column_in;
   logic [IMAGE_ROWS_W-1:0]  row_ff, row_in;
   logic [7:0]               filter_ff, filter_in;
   logic                     expect_ff, expect_in;
   // res_ff[k] holds column mod (k+1)
   logic [SLOT_W-1:0]        res_ff [MAX_PIXEL_BYTES];
   logic [SLOT_W-1:0]        res_in [MAX_PIXEL_BYTES];

   logic [PIXEL_BYTES_W-1:0] pb_eff;
   logic [CNT_W-1:0]         col_inc;
   logic [IMAGE_ROWS_W:0]    row_inc;
   logic                     accept;
   logic                     rend;
   logic                     iend;

   assign csr.ready = 1'b1;
   assign req.ready = take_ok;
   assign accept    = req.valid && take_ok;

   always_comb begin
      if (pixel_bytes_ff == '0) begin
         pb_eff = PIXEL_BYTES_W'(1);
      end else if (pixel_bytes_ff > PIXEL_BYTES_W'(MAX_PIXEL_BYTES)) begin
         pb_eff = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
      end else begin
         pb_eff = pixel_bytes_ff;
      end
      col_inc = CNT_W'(column_ff) + CNT_W'(1);
      row_inc = {1'b0, row_ff} + (IMAGE_ROWS_W+1)'(1);
      rend    = (col_inc >= CNT_W'(row_bytes_ff)) || (col_inc >= CNT_W'(MAX_ROW_BYTES));
      iend    = rend && (row_inc >= {1'b0, image_rows_ff});

      item.valid     = accept && !expect_ff;
      item.data      = req.data_byte;
      item.filter    = filter_ff;
      item.slot      = res_ff[SLOT_W'(pb_eff - PIXEL_BYTES_W'(1))];
      item.left_ok   = CNT_W'(column_ff) >= CNT_W'(pb_eff);
      item.above_ok  = (row_ff != '0);
      item.row_end   = rend;
      item.image_end = iend;

      rd_en   = item.valid;
      rd_addr = column_ff;
   end

   always_comb begin
      row_bytes_in   = row_bytes_ff;
      pixel_bytes_in = pixel_bytes_ff;
      image_rows_in  = image_rows_ff;
      column_in      = column_ff;
      row_in         = row_ff;
      filter_in      = filter_ff;
      expect_in      = expect_ff;
      res_in         = res_ff;

      if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_ROW_BYTES:   row_bytes_in   = csr.data[ROW_BYTES_W-1:0];
            CSR_PIXEL_BYTES: pixel_bytes_in = csr.data[PIXEL_BYTES_W-1:0];
            CSR_IMAGE_ROWS:  image_rows_in  = csr.data[IMAGE_ROWS_W-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         if (expect_ff) begin
            filter_in = req.data_byte;
            expect_in = 1'b0;
         end else if (rend) begin
            column_in = '0;
            expect_in = 1'b1;
            row_in    = iend ? '0 : row_inc[IMAGE_ROWS_W-1:0];
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
               res_in[k] = '0;
            end
         end else begin
            column_in = column_ff + COL_W'(1);
            for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
               res_in[k] = (res_ff[k] == SLOT_W'(k)) ? '0 : res_ff[k] + SLOT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff   <= ROW_BYTES_W'(1);
         pixel_bytes_ff <= PIXEL_BYTES_W'(1);
         image_rows_ff  <= IMAGE_ROWS_W'(1);
         column_ff      <= '0;
         row_ff         <= '0;
         filter_ff      <= '0;
         expect_ff      <= 1'b1;
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            res_ff[k] <= '0;
         end
      end else begin
         row_bytes_ff   <= row_bytes_in;
         pixel_bytes_ff <= pixel_bytes_in;
         image_rows_ff  <= image_rows_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
         filter_ff      <= filter_in;
         expect_ff      <= expect_in;
         res_ff         <= res_in;
      end
   end

endmodule

// ===== sv/psu_recon.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_recon
// Reconstruct stage: takes the above byte from the line store, the left and
// upper-left bytes from the per-slot history, applies the row filter, writes
// back, and feeds the output register.
// ----------------------------------------------------------------------------
module psu_recon import psu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic [7:0] above_data,
   output logic       take_ok,
   output logic       wr_en,
   output logic [7:0] wr_data,
   psu_rsp_if.source  rsp
);

   item_type   s1_ff, s1_in;
   logic [7:0] left_ff [MAX_PIXEL_BYTES];
   logic [7:0] left_in [MAX_PIXEL_BYTES];
   logic [7:0] upleft_ff [MAX_PIXEL_BYTES];
   logic [7:0] upleft_in [MAX_PIXEL_BYTES];
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_rend_ff;
   logic       out_iend_ff;

   logic       s1_fire;
   logic [7:0] nb_a;
   logic [7:0] nb_b;
   logic [7:0] nb_c;
   logic [8:0] avg_sum;
   logic [7:0] pixel;

   assign s1_fire = s1_ff.valid && (!out_valid_ff || rsp.ready);
   assign take_ok = !s1_ff.valid || s1_fire;

   always_comb begin
      nb_a    = s1_ff.left_ok ? left_ff[s1_ff.slot] : 8'd0;
      nb_b    = s1_ff.above_ok ? above_data : 8'd0;
      nb_c    = (s1_ff.left_ok && s1_ff.above_ok) ? upleft_ff[s1_ff.slot] : 8'd0;
      avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
      case (s1_ff.filter)
         FLT_SUB:   pixel = s1_ff.data + nb_a;
         FLT_UP:    pixel = s1_ff.data + nb_b;
         FLT_AVG:   pixel = s1_ff.data + avg_sum[8:1];
         FLT_PAETH: pixel = s1_ff.data + paeth_pred(nb_a, nb_b, nb_c);
         default:   pixel = s1_ff.data;
      endcase

      s1_in        = take_ok ? item : s1_ff;
      left_in      = left_ff;
      upleft_in    = upleft_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (s1_fire) begin
         left_in[s1_ff.slot]   = pixel;
         upleft_in[s1_ff.slot] = nb_b;
         out_valid_in          = 1'b1;
      end

      wr_en   = s1_fire;
      wr_data = pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            left_ff[k]   <= '0;
            upleft_ff[k] <= '0;
         end
      end else begin
         s1_ff        <= s1_in;
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
         upleft_ff    <= upleft_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_byte_ff <= pixel;
         out_rend_ff <= s1_ff.row_end;
         out_iend_ff <= s1_ff.image_end;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.pixel_byte = out_byte_ff;
   assign rsp.row_end    = out_rend_ff;
   assign rsp.image_end  = out_iend_ff;

endmodule

// ===== sv/png_scanline_unfilter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline filter reconstruction (none, sub, up, average, Paeth).
// ----------------------------------------------------------------------------
// req_chan carries the inflated stream one byte per transaction. The first
// byte of each row is the filter type and gives no result; each following
// data byte gives one rsp_chan transaction with the rebuilt byte, row_end on
// the last byte of a row and image_end on the last byte of the last row,
// after which the next image starts at row 0.
// csr_chan writes row_bytes (0), pixel_bytes (1) and image_rows (2); it is
// always ready and should be written while no data is in flight.
// A data byte accepted on req_chan passes the reconstruct register, then the
// output register. Throughput: one byte per cycle while rsp_chan does not
// stall; the line store is read in the accept cycle and written as the byte
// leaves the reconstruct stage. Filter bytes also occupy the input port.
// Reset clears the counters, the left/upper-left history and sets the
// registers to 1; the line store is not cleared and needs no sweep.
// When rsp_chan stalls, one result waits in the output register and one more
// in the reconstruct stage; then req_chan ready drops until space frees.
// ----------------------------------------------------------------------------
module png_scanline_unfilter import psu_pkg::*; #(
   parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   psu_req_if.sink   req_chan,
   psu_rsp_if.source rsp_chan,
   psu_csr_if.sink   csr_chan
);

`include "png_scanline_unfilter_defines.svh"

   localparam int COL_W = $clog2(MAX_ROW_BYTES);

   item_type         item;
   logic             take_ok;
   logic             rd_en;
   logic [COL_W-1:0] rd_addr;
   logic [7:0]       rd_data;
   logic             wr_en;
   logic [7:0]       wr_data;

   psu_seq #(.MAX_ROW_BYTES(MAX_ROW_BYTES)) u_seq (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .csr     (csr_chan),
      .take_ok (take_ok),
      .item    (item),
      .rd_en   (rd_en),
      .rd_addr (rd_addr)
   );

   psu_line_ram #(.MAX_ROW_BYTES(MAX_ROW_BYTES)) u_line_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_data (wr_data)
   );

   psu_recon u_recon (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .above_data (rd_data),
      .take_ok    (take_ok),
      .wr_en      (wr_en),
      .wr_data    (wr_data),
      .rsp        (rsp_chan)
   );

   `PSU_ASSERT_IMP(a_image_end_on_row_end, clock, reset,
      rsp_chan.valid && rsp_chan.image_end, rsp_chan.row_end)
   `PSU_ASSERT_IMP(a_item_has_slot, clock, reset, item.valid, take_ok)
   `PSU_ASSERT_NXT(a_filter_after_row_end, clock, reset,
      item.valid && item.row_end, !item.valid)

endmodule

// ===== tb/psu_unfilter_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psu_unfilter_check
// Watches the byte, result and register channels of the scanline unfilter,
// predicts each rebuilt byte with its own line store, left and upper-left
// history, and compares every result transaction with the oldest
// expectation, field by field.
// ----------------------------------------------------------------------------
module psu_unfilter_check import psu_pkg::*; (
   input  logic clock,
   input  logic reset,
   psu_req_if   req_mon,
   psu_rsp_if   rsp_mon,
   psu_csr_if   csr_mon,
   output int   fail_count,
   output int   pending
);

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       row_end;
      logic       image_end;
   } rebuilt_byte_type;

   rebuilt_byte_type          expected_bytes[$];

   logic [ROW_BYTES_W-1:0]    cfg_row_bytes;
   logic [PIXEL_BYTES_W-1:0]  cfg_pixel_bytes;
   logic [IMAGE_ROWS_W-1:0]   cfg_image_rows;

   logic [7:0]                line_store[MAX_ROW_BYTES_DEF];
   logic [7:0]                left_hist[MAX_PIXEL_BYTES];
   logic [7:0]                upleft_hist[MAX_PIXEL_BYTES];
   int                        column;
   int                        row;
   logic [7:0]                row_filter;
   bit                        want_filter;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report(input string what);
      fail_count++;
      $display("[%0t] psu check: %s", $time, what);
   endtask

   // Returns 1 and the rebuilt byte for a data byte, 0 for a filter byte.
   function automatic bit rebuild_byte(input logic [7:0] value,
                                       output rebuilt_byte_type res);
      int rb, pb, ir, col, slot;
      int a, b, c, sum, est, da, db, dc;
      rb = (cfg_row_bytes == 0) ? 1 : int'(cfg_row_bytes);
      if (rb > MAX_ROW_BYTES_DEF) rb = MAX_ROW_BYTES_DEF;
      pb = (cfg_pixel_bytes == 0) ? 1 : int'(cfg_pixel_bytes);
      if (pb > MAX_PIXEL_BYTES) pb = MAX_PIXEL_BYTES;
      ir = (cfg_image_rows == 0) ? 1 : int'(cfg_image_rows);
      res = '0;
      if (want_filter) begin
         row_filter  = value;
         want_filter = 1'b0;
         return 1'b0;
      end
      col = (column >= MAX_ROW_BYTES_DEF) ? MAX_ROW_BYTES_DEF - 1 : column;
      slot = col % pb;
      a = (col >= pb) ? int'(left_hist[slot]) : 0;
      b = (row > 0) ? int'(line_store[col]) : 0;
      c = (row > 0 && col >= pb) ? int'(upleft_hist[slot]) : 0;
      case (row_filter)
         FLT_SUB:   sum = value + a;
         FLT_UP:    sum = value + b;
         FLT_AVG:   sum = value + (a + b) / 2;
         FLT_PAETH: begin
            est = a + b - c;
            da  = (est > a) ? est - a : a - est;
            db  = (est > b) ? est - b : b - est;
            dc  = (est > c) ? est - c : c - est;
            if (da <= db && da <= dc) sum = value + a;
            else if (db <= dc)        sum = value + b;
            else                      sum = value + c;
         end
         default:   sum = value;
      endcase
      res.pixel_byte    = sum[7:0];
      left_hist[slot]   = sum[7:0];
      upleft_hist[slot] = b[7:0];
      line_store[col]   = sum[7:0];
      res.row_end   = (col + 1 >= rb);
      res.image_end = res.row_end && (row + 1 >= ir);
      if (res.row_end) begin
         column      = 0;
         want_filter = 1'b1;
         row         = res.image_end ? 0 : ((row + 1) & 16'hFFFF);
      end else begin
         column = col + 1;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      rebuilt_byte_type got;
      rebuilt_byte_type want;
      if (reset) begin
         cfg_row_bytes   = ROW_BYTES_W'(1);
         cfg_pixel_bytes = PIXEL_BYTES_W'(1);
         cfg_image_rows  = IMAGE_ROWS_W'(1);
         foreach (left_hist[i]) begin
            left_hist[i]   = '0;
            upleft_hist[i] = '0;
         end
         column      = 0;
         row         = 0;
         row_filter  = '0;
         want_filter = 1'b1;
         expected_bytes.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_ROW_BYTES:   cfg_row_bytes   = csr_mon.data[ROW_BYTES_W-1:0];
               CSR_PIXEL_BYTES: cfg_pixel_bytes = csr_mon.data[PIXEL_BYTES_W-1:0];
               CSR_IMAGE_ROWS:  cfg_image_rows  = csr_mon.data[IMAGE_ROWS_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (rebuild_byte(req_mon.data_byte, want)) expected_bytes.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.pixel_byte, rsp_mon.row_end, rsp_mon.image_end};
            if (expected_bytes.size() == 0) begin
               report($sformatf("result %02h with no transaction expected", got.pixel_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (got.pixel_byte !== want.pixel_byte)
                  report($sformatf("pixel_byte %02h, expected %02h",
                                   got.pixel_byte, want.pixel_byte));
               if (got.row_end !== want.row_end)
                  report($sformatf("row_end %b, expected %b", got.row_end, want.row_end));
               if (got.image_end !== want.image_end)
                  report($sformatf("image_end %b, expected %b",
                                   got.image_end, want.image_end));
            end
         end
      end
      pending = expected_bytes.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the PNG scanline unfilter. Sends directed rows
// for every filter code and the register corner values, one row that fills
// the line store as far as random rows reach, then random rows and
// reconfigurations under three sender/receiver idling mixes; the checker
// does the comparing.
// ----------------------------------------------------------------------------
module tb import psu_pkg::*;;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE      = 2'd3;
   localparam logic [7:0]           FLT_UNKNOWN_LO = FLT_PAETH + 8'd1;

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   fail_count;
   int   pending;
   int   random_bytes;
   int   row_len;
   int   col;
   bit   at_filter;

   psu_req_if req_chan();
   psu_rsp_if rsp_chan();
   psu_csr_if csr_chan();

   png_scanline_unfilter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   psu_unfilter_check byte_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_byte(input logic [7:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid     <= 1'b1;
      req_chan.data_byte <= value;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Well-formed rows: a filter code, then row_len data bytes.
   task automatic send_stream(input int count);
      logic [7:0] value;
      repeat (count) begin
         if (at_filter) begin
            if ($urandom_range(99) < 85) value = 8'($urandom_range(int'(FLT_PAETH)));
            else value = 8'($urandom_range(255, int'(FLT_UNKNOWN_LO)));
            at_filter = 1'b0;
            col       = 0;
         end else begin
            case ($urandom_range(9))
               0:       value = 8'h00;
               1:       value = 8'hFF;
               default: value = 8'($urandom);
            endcase
            col++;
            at_filter = (col >= row_len);
         end
         send_byte(value);
      end
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [15:0] rbytes, input logic [15:0] pbytes,
                               input logic [15:0] rows);
      logic [15:0]          value[4];
      logic [CSR_IDX_W-1:0] reg_sel[4];
      value   = '{rbytes, pbytes, rows, 16'($urandom)};
      reg_sel = '{CSR_ROW_BYTES, CSR_PIXEL_BYTES, CSR_IMAGE_ROWS, CSR_SPARE};
      for (int i = 0; i < 4; i++) begin
         csr_chan.valid <= 1'b1;
         csr_chan.index <= reg_sel[i];
         csr_chan.data  <= value[i];
         do @(posedge clock); while (!csr_chan.ready);
      end
      csr_chan.valid <= 1'b0;
      row_len = int'(rbytes[ROW_BYTES_W-1:0]);
      if (row_len == 0) row_len = 1;
      if (row_len > MAX_ROW_BYTES_DEF) row_len = MAX_ROW_BYTES_DEF;
   endtask

   task automatic random_block(input int target);
      int start, rb, pb, ir, count;
      start = random_bytes;
      while (random_bytes - start < target) begin
         case ($urandom_range(9))
            7, 8:    rb = $urandom_range(120, 17);
            9:       rb = 0;
            default: rb = $urandom_range(16, 1);
         endcase
         pb = $urandom_range(15);
         case ($urandom_range(9))
            0:       ir = 0;
            1:       ir = 65535;
            default: ir = $urandom_range(4, 1);
         endcase
         set_geometry({2'($urandom), 14'(rb)}, {12'($urandom), 4'(pb)}, 16'(ir));
         count = $urandom_range(4, 1) * (row_len + 1);
         if ($urandom_range(2) == 0) count += $urandom_range(row_len);
         send_stream(count);
         random_bytes += count;
         drain();
      end
   endtask

   initial begin
      logic [7:0] codes[7];
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = CSR_ROW_BYTES;
      csr_chan.data      = '0;
      send_idle_pct      = 16;
      recv_idle_pct      = 69;
      random_bytes       = 0;
      row_len            = 1;
      col                = 0;
      at_filter          = 1'b1;
      codes = '{FLT_NONE, FLT_SUB, FLT_UP, FLT_AVG, FLT_PAETH, FLT_UNKNOWN_LO, 8'hFF};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: one-byte rows, one-row images
      foreach (codes[i]) begin
         send_byte(codes[i]);
         send_byte(i[0] ? 8'h00 : 8'hFF);
      end
      drain();

      // zero registers behave as one
      set_geometry(16'h0000, 16'h0000, 16'h0000);
      send_byte(FLT_AVG);
      send_byte(8'hFF);
      send_byte(FLT_PAETH);
      send_byte(8'h7F);
      drain();

      // upper row size bits dropped, pixel size saturates; this row also fills
      // the line store as far as random rows reach
      set_geometry(16'hC078, 16'hFFFF, 16'h0001);
      send_stream(row_len + 1);
      drain();

      random_block(490);

      send_idle_pct = 69;
      recv_idle_pct = 16;
      random_block(490);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_block(480);

      if (fail_count == 0 && pending == 0) begin
         $display("** png_scanline_unfilter: PASSED **");
      end else begin
         $display("** png_scanline_unfilter: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("** png_scanline_unfilter: FAILED **");
      $finish;
   end

endmodule

// ===== png_scanline_unfilter.f =====
+incdir+sv
sv/psu_pkg.sv
sv/psu_req_if.sv
sv/psu_rsp_if.sv
sv/psu_csr_if.sv
sv/psu_line_ram.sv
sv/psu_seq.sv
sv/psu_recon.sv
sv/png_scanline_unfilter.sv
tb/psu_unfilter_check.sv
tb/tb.sv
